/* hw/rtl/trackball_swipe_direction_detector_macros.svh */
// Assertion macros shared by the swipe detector RTL.
`ifndef TRACKBALL_SWIPE_DIRECTION_DETECTOR_MACROS_SVH
`define TRACKBALL_SWIPE_DIRECTION_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSDD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tsdd_pkg.sv */
// Shared types, constants and helper functions of the swipe detector.
`timescale 1ns / 1ps
`default_nettype none

package tsdd_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_TH   = 2'd0,
        CFG_FIRE_DELAY = 2'd1,
        CFG_STOP_MS    = 2'd2,
        CFG_FIRE_TH    = 2'd3
    } t_cfg_index;

    // Reset values of the configuration registers.
    localparam logic [14:0] START_TH_RST   = 15'd0;
    localparam logic [15:0] FIRE_DELAY_RST = 16'd60;
    localparam logic [15:0] STOP_MS_RST    = 16'd30;
    localparam logic [14:0] FIRE_TH_RST    = 15'd2;

    // Gesture phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_MOVING = 3'b010,
        PH_LOCKED = 3'b100
    } t_phase;

    // Key event codes.
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_RIGHT = 3'd1,
        EV_LEFT  = 3'd2,
        EV_DOWN  = 3'd3,
        EV_UP    = 3'd4,
        EV_CLICK = 3'd5
    } t_key_event;

    typedef struct packed {
        logic signed [15:0] sum_x;
        logic signed [15:0] sum_y;
    } t_sums;

    // Absolute value of a 16-bit signed number, with -32768 clamped to 32767.
    function automatic logic [14:0] sat_abs(input logic signed [15:0] v);
        logic [15:0] mag;
        begin
            mag = v[15] ? (16'd0 - v) : v;
            sat_abs = mag[15] ? 15'h7FFF : mag[14:0];
        end
    endfunction

    // Signed 16-bit add that clamps at the ends of the range.
    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        begin
            s = {a[15], a} + {b[15], b};
            if (s[16] != s[15]) begin
                sat_add = s[16] ? 16'sh8000 : 16'sh7FFF;
            end else begin
                sat_add = s[15:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/trackball_swipe_direction_detector.sv */
// Top level of the trackball swipe direction detector.
`timescale 1ns / 1ps
`default_nettype none
`include "trackball_swipe_direction_detector_macros.svh"

// Usage:
// Each transfer on the input channel carries one trackball report: signed x
// and y deltas, a click flag and a millisecond timestamp. Every report yields
// exactly one transfer on the output channel with a key event code (none,
// right, left, down, up or click), in report order.
// A report is first captured in an input register. Once the output register
// is empty or is being emptied, the gesture state is read and updated and the
// event is written to the output register, from which the result is offered.
// One report is taken per cycle while the receiver does not stall; the
// gesture state update is the loop that sets this rate.
// When the receiver stalls, the output register holds its event and the input
// register holds one more report; the input ready drops only when both are
// full, and a pending report moves on in the cycle the result is taken.
// The configuration channel is always ready and writes one of four registers
// per transfer; it is meant to be used while no report is in flight.
// Synchronous active-low reset empties both registers, restores the default
// thresholds and delays, clears the sums and returns the gesture to idle.

module trackball_swipe_direction_detector (
    input  var logic               i_clk,
    input  var logic               i_rst_n,

    input  var logic               i_in_valid,
    output var logic               o_in_ready,
    input  var logic signed [15:0] i_delta_x,
    input  var logic signed [15:0] i_delta_y,
    input  var logic               i_click,
    input  var logic [31:0]        i_time_ms,

    output var logic               o_out_valid,
    input  var logic               i_out_ready,
    output var logic [2:0]         o_key_event,

    input  var logic               i_cfg_valid,
    output var logic               o_cfg_ready,
    input  var logic [1:0]         i_cfg_index,
    input  var logic [15:0]        i_cfg_data
);
    import tsdd_pkg::*;

    // Configuration registers.
    logic [14:0] r_start_th;
    logic [15:0] r_fire_delay;
    logic [15:0] r_stop_ms;
    logic [14:0] r_fire_th;

    // Input register.
    logic               r_in_vld;
    logic signed [15:0] r_in_dx;
    logic signed [15:0] r_in_dy;
    logic               r_in_click;
    logic [31:0]        r_in_time;

    // Output register.
    logic       r_out_vld;
    t_key_event r_out_key;
    t_key_event n_out_key;

    // Gesture state.
    t_phase             r_phase;
    t_phase             n_phase;
    logic signed [15:0] r_sum_x;
    logic signed [15:0] n_sum_x;
    logic signed [15:0] r_sum_y;
    logic signed [15:0] n_sum_y;
    logic [31:0]        r_start_stamp;
    logic [31:0]        n_start_stamp;
    logic [31:0]        r_last_stamp;
    logic [31:0]        n_last_stamp;

    logic       w_proc;
    logic       w_motion;
    logic       w_start;
    logic [31:0] w_since_start;
    logic [31:0] w_since_motion;
    t_sums      w_moved_sums;
    t_key_event w_dir_event;

    // The report in the input register is processed whenever the output
    // register is empty or is being emptied in this cycle.
    assign w_proc      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_proc;
    assign o_out_valid = r_out_vld;
    assign o_key_event = r_out_key;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_th   <= START_TH_RST;
            r_fire_delay <= FIRE_DELAY_RST;
            r_stop_ms    <= STOP_MS_RST;
            r_fire_th    <= FIRE_TH_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_START_TH:   r_start_th   <= i_cfg_data[14:0];
                CFG_FIRE_DELAY: r_fire_delay <= i_cfg_data;
                CFG_STOP_MS:    r_stop_ms    <= i_cfg_data;
                CFG_FIRE_TH:    r_fire_th    <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: loads on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_dx    <= i_delta_x;
            r_in_dy    <= i_delta_y;
            r_in_click <= i_click;
            r_in_time  <= i_time_ms;
        end
    end

    // Per-report terms. Time differences wrap modulo 2^32.
    assign w_motion       = (r_in_dx != 16'sd0) || (r_in_dy != 16'sd0);
    assign w_start        = w_motion && ((sat_abs(r_in_dx) >= r_start_th) ||
                                         (sat_abs(r_in_dy) >= r_start_th));
    assign w_since_start  = r_in_time - r_start_stamp;
    assign w_since_motion = r_in_time - r_last_stamp;

    // Sums as they stand after this report's motion is added while moving;
    // the direction is decided on these.
    assign w_moved_sums.sum_x = w_motion ? sat_add(r_sum_x, r_in_dx) : r_sum_x;
    assign w_moved_sums.sum_y = w_motion ? sat_add(r_sum_y, r_in_dy) : r_sum_y;

    tsdd_decide u_decide (
        .i_sums    (w_moved_sums),
        .i_fire_th (r_fire_th),
        .o_event   (w_dir_event)
    );

    always_comb begin
        n_phase       = r_phase;
        n_sum_x       = r_sum_x;
        n_sum_y       = r_sum_y;
        n_start_stamp = r_start_stamp;
        n_last_stamp  = r_last_stamp;
        n_out_key     = EV_NONE;

        if (r_in_click) begin
            // A click reports itself and leaves the gesture untouched.
            n_out_key = EV_CLICK;
        end else begin
            unique case (r_phase)
                PH_MOVING: begin
                    n_sum_x = w_moved_sums.sum_x;
                    n_sum_y = w_moved_sums.sum_y;
                    if (w_motion) begin
                        n_last_stamp = r_in_time;
                    end
                    // The check locks the gesture whether or not a key fires.
                    if (w_since_start >= {16'd0, r_fire_delay}) begin
                        n_out_key    = w_dir_event;
                        n_phase      = PH_LOCKED;
                        n_last_stamp = r_in_time;
                    end
                end
                PH_LOCKED: begin
                    if (w_motion) begin
                        n_last_stamp = r_in_time;
                    end else if (w_since_motion >= {16'd0, r_stop_ms}) begin
                        n_sum_x = 16'sd0;
                        n_sum_y = 16'sd0;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    // Idle: enough motion on either axis opens a gesture.
                    if (w_start) begin
                        n_sum_x       = r_in_dx;
                        n_sum_y       = r_in_dy;
                        n_start_stamp = r_in_time;
                        n_last_stamp  = r_in_time;
                        n_phase       = PH_MOVING;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_sum_x       <= 16'sd0;
            r_sum_y       <= 16'sd0;
            r_start_stamp <= 32'd0;
            r_last_stamp  <= 32'd0;
        end else if (w_proc) begin
            r_phase       <= n_phase;
            r_sum_x       <= n_sum_x;
            r_sum_y       <= n_sum_y;
            r_start_stamp <= n_start_stamp;
            r_last_stamp  <= n_last_stamp;
        end
    end

    // Output register: filled by a processed report, emptied by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_key <= n_out_key;
        end
    end

    // A processed click always comes out as a click event.
    `TSDD_ASSERT_NEXT(a_click_event, w_proc && r_in_click, r_out_key == EV_CLICK,
        "click report did not produce a click event")

    // Only the fire check of a moving gesture can produce a direction.
    `TSDD_ASSERT_NEXT(a_dir_only_moving,
        w_proc && !r_in_click && (r_phase != PH_MOVING),
        r_out_key == EV_NONE, "direction event outside a moving gesture")

    // The sums are always cleared while idle.
    `TSDD_ASSERT_SAME(a_idle_sums_zero, r_phase == PH_IDLE,
        (r_sum_x == 16'sd0) && (r_sum_y == 16'sd0), "nonzero sums while idle")

endmodule

`default_nettype wire

/* hw/rtl/tsdd_decide.sv */
// Direction decision from the accumulated motion sums.
`timescale 1ns / 1ps
`default_nettype none

module tsdd_decide (
    input  var tsdd_pkg::t_sums       i_sums,
    input  var logic [14:0]           i_fire_th,
    output var tsdd_pkg::t_key_event  o_event
);
    import tsdd_pkg::*;

    logic [14:0] w_ax;
    logic [14:0] w_ay;

    assign w_ax = sat_abs(i_sums.sum_x);
    assign w_ay = sat_abs(i_sums.sum_y);

    // The x axis wins a tie; a sum that is not positive means left or up.
    always_comb begin
        if (w_ax < i_fire_th && w_ay < i_fire_th) begin
            o_event = EV_NONE;
        end else if (w_ax >= w_ay) begin
            o_event = (i_sums.sum_x > 16'sd0) ? EV_RIGHT : EV_LEFT;
        end else begin
            o_event = (i_sums.sum_y > 16'sd0) ? EV_DOWN : EV_UP;
        end
    end

endmodule

`default_nettype wire
